// File: rtl/lrst_pkg.sv
// lrst_pkg: shared types, codes and table builders for the logistic regression trainer.
// Standalone; used by logistic_regression_sgd_trainer_unit.
`timescale 1ns / 1ps
`default_nettype none

package lrst_pkg;

    localparam int SIG_ENTRIES   = 1024;
    localparam int LOG_ENTRIES   = 1024;
    localparam int MAX_BATCH_DEF = 1024;

    localparam longint unsigned LN2_Q32  = 64'd2977044472;
    localparam longint unsigned EINV_Q32 = 64'd1580030169;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        OP_TRAIN   = 2'd0,
        OP_PREDICT = 2'd1,
        OP_LOAD    = 2'd2,
        OP_SPARE   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BATCH_LENGTH    = 3'd0,
        REG_STEP_SIZE       = 3'd1,
        REG_START_COEF_ONE  = 3'd2,
        REG_START_COEF_TWO  = 3'd3,
        REG_START_COEF_BIAS = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] feature_one;
        logic signed [15:0] feature_two;
        logic               label;
        logic               epoch_end;
    } sample_t;

    typedef struct packed {
        logic [15:0]        prediction;
        logic               loss_valid;
        logic [31:0]        epoch_loss;
        logic signed [31:0] coef_one_out;
        logic signed [31:0] coef_two_out;
        logic signed [31:0] coef_bias_out;
    } result_t;

    typedef logic [15:0] sig_tab_t [SIG_ENTRIES];
    typedef logic [31:0] log_tab_t [LOG_ENTRIES];

    // shift-and-subtract quotient, used only while building the tables
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // e^(-a), a >= 0 in Q.16, result Q.32
    function automatic longint unsigned exp_neg(input longint a);
        longint          f;
        longint          n;
        longint          term;
        longint          sum;
        longint unsigned r;
        f    = a & 64'sd65535;
        n    = a >>> 16;
        term = 64'sd1 <<< 32;
        sum  = term;
        for (int k = 1; k <= 16; k++)
        begin
            term = longint'(udiv($unsigned(term * f), $unsigned(longint'(k) <<< 16)));
            sum  = ((k & 1) != 0) ? sum - term : sum + term;
        end
        r = longint'(sum);
        for (int j = 0; j < 64; j++)
        begin
            if (longint'(j) < n)
                r = (r * EINV_Q32) >> 32;
        end
        return r;
    endfunction

    function automatic sig_tab_t build_sig_tab();
        sig_tab_t        t;
        longint          x;
        longint          a;
        longint unsigned e;
        longint unsigned d;
        longint unsigned s;
        for (int i = 0; i < SIG_ENTRIES; i++)
        begin
            x = longint'(udiv($unsigned((2 * longint'(i) + 1) <<< 20),
                              $unsigned(2 * longint'(SIG_ENTRIES))))
                - (64'sd8 <<< 16);
            a = (x < 0) ? -x : x;
            e = exp_neg(a);
            d = (64'd1 << 32) + e;
            if (x >= 0)
                s = udiv((64'd1 << 48) + (d >> 1), d);
            else
                s = udiv((e << 16) + (d >> 1), d);
            t[i] = (s > 64'd65535) ? 16'hFFFF : s[15:0];
        end
        return t;
    endfunction

    // -ln((2i+1)/(2N)) in Q16.16, atanh series
    function automatic log_tab_t build_log_tab();
        log_tab_t        t;
        longint unsigned num;
        longint unsigned den;
        longint unsigned m;
        longint unsigned tt;
        longint unsigned t2;
        longint unsigned pw;
        longint unsigned sum;
        longint unsigned val;
        longint unsigned ex;
        for (int i = 0; i < LOG_ENTRIES; i++)
        begin
            num = 2 * longint'(i) + 1;
            den = 2 * longint'(LOG_ENTRIES);
            ex  = 0;
            for (int j = 0; j < 64; j++)
            begin
                if ((num << ex) < den)
                    ex = ex + 1;
            end
            m   = num << ex;
            tt  = udiv((m - den) << 32, m + den);
            t2  = (tt * tt) >> 32;
            pw  = tt;
            sum = 0;
            for (int k = 0; k < 16; k++)
            begin
                sum = sum + udiv(pw, $unsigned(2 * longint'(k) + 1));
                pw  = (pw * t2) >> 32;
            end
            val  = ex * LN2_Q32 - 2 * sum;
            t[i] = 32'((val + 64'h8000) >> 16);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// File: rtl/logistic_regression_sgd_trainer_unit.sv
// Top level of the two-feature logistic regression mini-batch SGD trainer.
// Depends on lrst_pkg (types, codes, sigmoid and -ln tables).
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Signals                               | Word
// ----------+---------------------------------------+--------------------------
// sample    | sample_valid, sample_stall, sample    | lrst_pkg::sample_t
// result    | result_valid, result_stall, result    | lrst_pkg::result_t
// config    | cfg_wr_en, cfg_index, cfg_data        | 32 bit register write
//
// One word at a time; one 33x17 multiplier serves the dot-product, gradient
// and update steps. Predict/load run MUL1, MUL2, SUMZ, LOOK, FIN; train adds
// ERR, G1, G2, G3; closing a batch adds three coefficient updates (UA-UD).
// sample_stall is high while a word is in work; a result held by result_stall
// only delays the final step. rst_n resets all state; no clearing pass.

module logistic_regression_sgd_trainer_unit #(
    parameter int MAX_BATCH = lrst_pkg::MAX_BATCH_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              sample_valid,
    output logic                             sample_stall,
    input  wire lrst_pkg::sample_t           sample,
    output logic                             result_valid,
    input  wire                              result_stall,
    output lrst_pkg::result_t                result,
    input  wire                              cfg_wr_en,
    input  wire [lrst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [31:0]                       cfg_data
);

    localparam int FILL_W = $clog2(MAX_BATCH + 1);
    localparam int BL_W   = (FILL_W > 11) ? FILL_W : 11;
    localparam int SIG_IW = $clog2(lrst_pkg::SIG_ENTRIES);
    localparam int LOG_IW = $clog2(lrst_pkg::LOG_ENTRIES);

    localparam lrst_pkg::sig_tab_t SIG_TAB = lrst_pkg::build_sig_tab();
    localparam lrst_pkg::log_tab_t LOG_TAB = lrst_pkg::build_log_tab();

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_SUMZ, S_LOOK, S_ERR,
        S_G1, S_G2, S_G3, S_UA, S_UB, S_UC, S_UD, S_FIN
    } state_t;

    state_t               state_reg, state_next;
    lrst_pkg::sample_t    item_reg, item_next;
    logic signed [31:0]   coef_one_reg, coef_one_next;
    logic signed [31:0]   coef_two_reg, coef_two_next;
    logic signed [31:0]   coef_bias_reg, coef_bias_next;
    logic signed [47:0]   grad_one_reg, grad_one_next;
    logic signed [47:0]   grad_two_reg, grad_two_next;
    logic signed [31:0]   grad_bias_reg, grad_bias_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [31:0]          loss_reg, loss_next;
    logic [15:0]          p_reg, p_next;
    logic signed [16:0]   err_reg, err_next;
    logic signed [49:0]   prod_reg, prod_next;
    logic signed [65:0]   acc_reg, acc_next;
    logic [1:0]           k_reg, k_next;
    logic [10:0]          blen_cfg_reg;
    logic [15:0]          step_reg;
    logic signed [31:0]   start_one_reg, start_two_reg, start_bias_reg;
    lrst_pkg::result_t    res_reg, res_next;
    logic                 res_valid_reg, res_valid_next;

    // shared multiplier
    logic signed [32:0]   mul_a;
    logic signed [16:0]   mul_b;
    logic signed [47:0]   upd_grad;
    logic signed [31:0]   upd_coef;

    // scratch
    logic                 is_train;
    logic [31:0]          u32;
    logic [31+SIG_IW:0]   sig_prod;
    logic [SIG_IW-1:0]    sig_idx;
    logic [16:0]          q17;
    logic [15:0]          q16;
    logic [16+LOG_IW:0]   log_prod;
    logic [32:0]          loss_sum33;
    logic signed [49:0]   g_sum;
    logic signed [32:0]   gb_sum;
    logic [BL_W-1:0]      bl_ext, blen, fill_inc;
    logic signed [39:0]   c_new;
    logic signed [31:0]   c_sat;

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign is_train     = (item_reg.operation == lrst_pkg::OP_TRAIN);

    always_comb
    begin
        case (k_reg)
            2'd0:    upd_grad = grad_one_reg;
            2'd1:    upd_grad = grad_two_reg;
            default: upd_grad = {{4{grad_bias_reg[31]}}, grad_bias_reg, 12'd0};
        endcase
        case (k_reg)
            2'd0:    upd_coef = coef_one_reg;
            2'd1:    upd_coef = coef_two_reg;
            default: upd_coef = coef_bias_reg;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_MUL1:  begin mul_a = 33'(coef_one_reg); mul_b = 17'(item_reg.feature_one); end
            S_MUL2:  begin mul_a = 33'(coef_two_reg); mul_b = 17'(item_reg.feature_two); end
            S_G1:    begin mul_a = 33'(err_reg);      mul_b = 17'(item_reg.feature_one); end
            S_G2:    begin mul_a = 33'(err_reg);      mul_b = 17'(item_reg.feature_two); end
            S_UA:    begin mul_a = 33'($signed(upd_grad[47:24]));
                           mul_b = $signed({1'b0, step_reg}); end
            S_UB:    begin mul_a = $signed({9'd0, upd_grad[23:0]});
                           mul_b = $signed({1'b0, step_reg}); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        coef_one_next  = coef_one_reg;
        coef_two_next  = coef_two_reg;
        coef_bias_next = coef_bias_reg;
        grad_one_next  = grad_one_reg;
        grad_two_next  = grad_two_reg;
        grad_bias_next = grad_bias_reg;
        fill_next      = fill_reg;
        loss_next      = loss_reg;
        p_next         = p_reg;
        err_next       = err_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        k_next         = k_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;

        // sigmoid index: z in acc, u = z + 8.0
        u32      = acc_reg[31:0] ^ 32'h8000_0000;
        sig_prod = (32+SIG_IW)'(u32) * (32+SIG_IW)'(lrst_pkg::SIG_ENTRIES);
        if (acc_reg < -66'sd2147483648)
            sig_idx = '0;
        else if (acc_reg >= 66'sd2147483648)
            sig_idx = SIG_IW'(lrst_pkg::SIG_ENTRIES - 1);
        else
            sig_idx = sig_prod[32 +: SIG_IW];

        // -ln index from the clamped class probability
        q17 = item_reg.label ? {1'b0, p_reg} : (17'd65536 - {1'b0, p_reg});
        if (q17 == 17'd0)
            q16 = 16'd1;
        else if (q17 > 17'd65535)
            q16 = 16'hFFFF;
        else
            q16 = q17[15:0];
        log_prod   = (17+LOG_IW)'(q16) * (17+LOG_IW)'(lrst_pkg::LOG_ENTRIES);
        loss_sum33 = {1'b0, loss_reg} + {1'b0, LOG_TAB[log_prod[16 +: LOG_IW]]};

        g_sum  = '0;
        gb_sum = 33'(grad_bias_reg) + 33'(err_reg);

        bl_ext   = BL_W'(blen_cfg_reg);
        if (bl_ext == '0)
            blen = BL_W'(1);
        else if (bl_ext > BL_W'(MAX_BATCH))
            blen = BL_W'(MAX_BATCH);
        else
            blen = bl_ext;
        fill_inc = BL_W'(fill_reg) + BL_W'(1);

        c_new = 40'(upd_coef) - 40'($signed(acc_reg[65:28]));
        if (c_new[39:31] != {9{c_new[31]}})
            c_sat = c_new[39] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            c_sat = c_new[31:0];

        if (res_valid_reg && !result_stall)
            res_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    item_next  = sample;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                prod_next  = mul_a * mul_b;
                acc_next   = 66'(coef_bias_reg) <<< 12;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                prod_next  = mul_a * mul_b;
                acc_next   = acc_reg + 66'(prod_reg);
                state_next = S_SUMZ;
            end
            S_SUMZ:
            begin
                acc_next   = acc_reg + 66'(prod_reg);
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                p_next     = SIG_TAB[sig_idx];
                state_next = is_train ? S_ERR : S_FIN;
            end
            S_ERR:
            begin
                err_next   = $signed({1'b0, p_reg}) - (item_reg.label ? 17'sh10000 : 17'sd0);
                loss_next  = loss_sum33[32] ? 32'hFFFF_FFFF : loss_sum33[31:0];
                state_next = S_G1;
            end
            S_G1:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_G2;
            end
            S_G2:
            begin
                g_sum = 50'(grad_one_reg) + prod_reg;
                if (g_sum[49:47] != {3{g_sum[47]}})
                    grad_one_next = g_sum[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                else
                    grad_one_next = g_sum[47:0];
                prod_next  = mul_a * mul_b;
                state_next = S_G3;
            end
            S_G3:
            begin
                g_sum = 50'(grad_two_reg) + prod_reg;
                if (g_sum[49:47] != {3{g_sum[47]}})
                    grad_two_next = g_sum[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                else
                    grad_two_next = g_sum[47:0];
                if (gb_sum[32] != gb_sum[31])
                    grad_bias_next = gb_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                else
                    grad_bias_next = gb_sum[31:0];
                fill_next = fill_inc[FILL_W-1:0];
                if (fill_inc >= blen)
                begin
                    k_next     = 2'd0;
                    state_next = S_UA;
                end
                else
                    state_next = S_FIN;
            end
            S_UA:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_UB;
            end
            S_UB:
            begin
                acc_next   = 66'(prod_reg) <<< 24;
                prod_next  = mul_a * mul_b;
                state_next = S_UC;
            end
            S_UC:
            begin
                acc_next   = acc_reg + 66'(prod_reg);
                state_next = S_UD;
            end
            S_UD:
            begin
                case (k_reg)
                    2'd0:    coef_one_next  = c_sat;
                    2'd1:    coef_two_next  = c_sat;
                    default: coef_bias_next = c_sat;
                endcase
                if (k_reg == 2'd2)
                begin
                    grad_one_next  = '0;
                    grad_two_next  = '0;
                    grad_bias_next = '0;
                    fill_next      = '0;
                    state_next     = S_FIN;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_UA;
                end
            end
            S_FIN:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next         = 1'b1;
                    res_next.prediction    = p_reg;
                    res_next.loss_valid    = is_train && item_reg.epoch_end;
                    res_next.epoch_loss    = (is_train && item_reg.epoch_end) ? loss_reg : '0;
                    res_next.coef_one_out  = coef_one_reg;
                    res_next.coef_two_out  = coef_two_reg;
                    res_next.coef_bias_out = coef_bias_reg;
                    if (item_reg.operation == lrst_pkg::OP_LOAD)
                    begin
                        coef_one_next          = start_one_reg;
                        coef_two_next          = start_two_reg;
                        coef_bias_next         = start_bias_reg;
                        res_next.coef_one_out  = start_one_reg;
                        res_next.coef_two_out  = start_two_reg;
                        res_next.coef_bias_out = start_bias_reg;
                    end
                    if ((item_reg.operation == lrst_pkg::OP_LOAD)
                        || (is_train && item_reg.epoch_end))
                    begin
                        grad_one_next  = '0;
                        grad_two_next  = '0;
                        grad_bias_next = '0;
                        fill_next      = '0;
                        loss_next      = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            coef_one_reg   <= '0;
            coef_two_reg   <= '0;
            coef_bias_reg  <= '0;
            grad_one_reg   <= '0;
            grad_two_reg   <= '0;
            grad_bias_reg  <= '0;
            fill_reg       <= '0;
            loss_reg       <= '0;
            p_reg          <= '0;
            err_reg        <= '0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            k_reg          <= '0;
            res_reg        <= '0;
            res_valid_reg  <= 1'b0;
            blen_cfg_reg   <= 11'd32;
            step_reg       <= 16'd655;
            start_one_reg  <= '0;
            start_two_reg  <= '0;
            start_bias_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            item_reg       <= item_next;
            coef_one_reg   <= coef_one_next;
            coef_two_reg   <= coef_two_next;
            coef_bias_reg  <= coef_bias_next;
            grad_one_reg   <= grad_one_next;
            grad_two_reg   <= grad_two_next;
            grad_bias_reg  <= grad_bias_next;
            fill_reg       <= fill_next;
            loss_reg       <= loss_next;
            p_reg          <= p_next;
            err_reg        <= err_next;
            prod_reg       <= prod_next;
            acc_reg        <= acc_next;
            k_reg          <= k_next;
            res_reg        <= res_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    lrst_pkg::REG_BATCH_LENGTH:    blen_cfg_reg   <= cfg_data[10:0];
                    lrst_pkg::REG_STEP_SIZE:       step_reg       <= cfg_data[15:0];
                    lrst_pkg::REG_START_COEF_ONE:  start_one_reg  <= cfg_data;
                    lrst_pkg::REG_START_COEF_TWO:  start_two_reg  <= cfg_data;
                    lrst_pkg::REG_START_COEF_BIAS: start_bias_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // batch count never passes the largest batch
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        BL_W'(fill_reg) <= BL_W'(MAX_BATCH))
        else $error("batch fill beyond MAX_BATCH");

    // an accepted word keeps the input stalled next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("input not stalled after accept");

    // a new result appears only from the final step
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_FIN))
        else $error("result raised outside final step");

    // a fresh update pass starts only from the gradient step
    a_update_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UA) && (k_reg == 2'd0) |-> $past(state_reg == S_G3))
        else $error("update pass entered unexpectedly");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for logistic_regression_sgd_trainer_unit.
// Needs lrst_pkg for the word types, operation codes and register indexes.
`timescale 1ns / 1ps

module tb_top;
    import lrst_pkg::*;

    localparam int           LIMIT_CYCLES = 1000000;
    localparam int           RND_PER_PHASE = 250;
    localparam longint unsigned K_LN2  = 64'd2977044472;
    localparam longint unsigned K_EINV = 64'd1580030169;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    logistic_regression_sgd_trainer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Lookup tables, rebuilt here with plain integer arithmetic
    // ------------------------------------------------------------------
    logic [15:0] sig_lut  [1024];
    logic [31:0] nlog_lut [1024];

    // e^(-a) in Q.32, a >= 0 in Q.16; Taylor series on the fraction,
    // then one multiply by 1/e per whole unit
    function automatic longint unsigned decay_q32(input longint a);
        longint          frac;
        longint          whole;
        longint          term;
        longint          acc;
        longint unsigned r;
        frac  = a & 64'sd65535;
        whole = a >>> 16;
        term  = 64'sd1 <<< 32;
        acc   = term;
        for (int k = 1; k <= 16; k++)
        begin
            term = (term * frac) / (longint'(k) <<< 16);
            acc  = (k % 2 == 1) ? acc - term : acc + term;
        end
        r = longint'(acc);
        while (whole > 0)
        begin
            r     = (r * K_EINV) >> 32;
            whole = whole - 1;
        end
        return r;
    endfunction

    task automatic fill_luts();
        longint          x;
        longint          mag;
        longint unsigned ev;
        longint unsigned dv;
        longint unsigned sv;
        longint unsigned num;
        longint unsigned den;
        longint unsigned mv;
        longint unsigned tv;
        longint unsigned t2;
        longint unsigned pw;
        longint unsigned acc;
        longint unsigned val;
        longint unsigned ex;
        for (int i = 0; i < 1024; i++)
        begin
            // bin centre of z in [-8, 8), Q.16
            x   = ((2 * longint'(i) + 1) <<< 20) / 2048 - (64'sd8 <<< 16);
            mag = (x < 0) ? -x : x;
            ev  = decay_q32(mag);
            dv  = (64'd1 << 32) + ev;
            if (x >= 0)
                sv = ((64'd1 << 48) + dv / 2) / dv;
            else
                sv = ((ev << 16) + dv / 2) / dv;
            sig_lut[i] = (sv > 64'd65535) ? 16'hFFFF : sv[15:0];
        end
        for (int i = 0; i < 1024; i++)
        begin
            // -ln of the bin centre: normalise by powers of two, atanh series
            num = 2 * longint'(i) + 1;
            den = 2048;
            ex  = 0;
            while ((num << ex) < den)
                ex = ex + 1;
            mv  = num << ex;
            tv  = ((mv - den) << 32) / (mv + den);
            t2  = (tv * tv) >> 32;
            pw  = tv;
            acc = 0;
            for (int k = 0; k < 16; k++)
            begin
                acc = acc + pw / (2 * longint'(k) + 1);
                pw  = (pw * t2) >> 32;
            end
            val = ex * K_LN2 - 2 * acc;
            nlog_lut[i] = 32'((val + 64'h8000) >> 16);
        end
    endtask

    // ------------------------------------------------------------------
    // Trainer model: configuration copy and training state
    // ------------------------------------------------------------------
    logic [10:0]        m_batch_len;
    logic [15:0]        m_step;
    logic signed [31:0] m_start_one;
    logic signed [31:0] m_start_two;
    logic signed [31:0] m_start_bias;
    logic signed [31:0] m_coef_one;
    logic signed [31:0] m_coef_two;
    logic signed [31:0] m_coef_bias;
    longint             m_grad_one;
    longint             m_grad_two;
    longint             m_grad_bias;
    int                 m_fill;
    logic [31:0]        m_loss;

    function automatic longint clip_signed(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function void drop_batch();
        m_grad_one  = 0;
        m_grad_two  = 0;
        m_grad_bias = 0;
        m_fill      = 0;
    endfunction

    // One word in, the expected answer out; train and load advance state
    function result_t train_step(input sample_t s);
        result_t         r;
        longint          f1;
        longint          f2;
        longint          zq;
        longint          uq;
        longint          p;
        longint          q;
        longint          err;
        longint          blen;
        longint          st;
        longint unsigned ls;
        int              idx;
        f1 = longint'(s.feature_one);
        f2 = longint'(s.feature_two);
        zq = longint'(m_coef_one) * f1 + longint'(m_coef_two) * f2
             + longint'(m_coef_bias) * 4096;
        uq = zq + (64'sd8 <<< 28);
        if (uq < 0)
            idx = 0;
        else if (uq >= (64'sd16 <<< 28))
            idx = 1023;
        else
            idx = int'((uq * 1024) >>> 32);
        p = longint'(sig_lut[idx]);
        r = '0;
        if (op_t'(s.operation) == OP_TRAIN)
        begin
            q   = s.label ? p : 65536 - p;
            err = p - (s.label ? 65536 : 0);
            if (q < 1)
                q = 1;
            if (q > 65535)
                q = 65535;
            ls = longint'(m_loss) + longint'(nlog_lut[int'((q * 1024) >>> 16)]);
            m_loss      = (ls > 64'hFFFFFFFF) ? 32'hFFFFFFFF : ls[31:0];
            m_grad_one  = clip_signed(m_grad_one + err * f1, 48);
            m_grad_two  = clip_signed(m_grad_two + err * f2, 48);
            m_grad_bias = clip_signed(m_grad_bias + err, 32);
            blen = longint'(m_batch_len);
            if (blen < 1)
                blen = 1;
            if (blen > 1024)
                blen = 1024;
            m_fill = m_fill + 1;
            if (m_fill >= blen)
            begin
                st = longint'(m_step);
                m_coef_one  = 32'(clip_signed(longint'(m_coef_one)
                              - ((st * m_grad_one) >>> 28), 32));
                m_coef_two  = 32'(clip_signed(longint'(m_coef_two)
                              - ((st * m_grad_two) >>> 28), 32));
                m_coef_bias = 32'(clip_signed(longint'(m_coef_bias)
                              - ((st * m_grad_bias) >>> 16), 32));
                drop_batch();
            end
            if (s.epoch_end)
            begin
                r.loss_valid = 1'b1;
                r.epoch_loss = m_loss;
                m_loss       = '0;
                drop_batch();
            end
        end
        else if (op_t'(s.operation) == OP_LOAD)
        begin
            m_coef_one  = m_start_one;
            m_coef_two  = m_start_two;
            m_coef_bias = m_start_bias;
            drop_batch();
            m_loss = '0;
        end
        // predict and the spare code leave the state alone
        r.prediction    = p[15:0];
        r.coef_one_out  = m_coef_one;
        r.coef_two_out  = m_coef_two;
        r.coef_bias_out = m_coef_bias;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    int cycles;
    int errors;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sample driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    sample_t pending_samples [$];
    result_t predicted_results [$];
    int      burst_left;
    int      gap_left;

    always @(posedge clk)
    begin
        logic    nxt_valid;
        sample_t nxt_word;
        nxt_valid = sample_valid;
        nxt_word  = sample;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                predicted_results = {predicted_results, train_step(sample)};
                void'(pending_samples.pop_front());
                nxt_valid = 1'b0;
            end
            // a word on offer stays put until taken
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_samples.size() > 0)
                begin
                    nxt_valid = 1'b1;
                    nxt_word  = pending_samples[0];
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        case ($urandom_range(0, 3))
                            0, 1:    gap_left <= 0;
                            2:       gap_left <= $urandom_range(1, 4);
                            default: gap_left <= $urandom_range(5, 20);
                        endcase
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
        sample_valid <= nxt_valid;
        sample       <= nxt_word;
    end

    // ------------------------------------------------------------------
    // Result monitor and stall pattern
    // ------------------------------------------------------------------
    int stall_mode;
    int stall_left;

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("unexpected result word %h", result);
                errors <= errors + 1;
            end
            else
            begin
                want = predicted_results.pop_front();
                if (result !== want)
                    errors <= errors + 1;
                if (result.prediction !== want.prediction)
                    $error("prediction: expected %0d, got %0d",
                           want.prediction, result.prediction);
                if (result.loss_valid !== want.loss_valid)
                    $error("loss_valid: expected %0d, got %0d",
                           want.loss_valid, result.loss_valid);
                if (result.epoch_loss !== want.epoch_loss)
                    $error("epoch_loss: expected %0d, got %0d",
                           want.epoch_loss, result.epoch_loss);
                if (result.coef_one_out !== want.coef_one_out)
                    $error("coef_one_out: expected %0d, got %0d",
                           want.coef_one_out, result.coef_one_out);
                if (result.coef_two_out !== want.coef_two_out)
                    $error("coef_two_out: expected %0d, got %0d",
                           want.coef_two_out, result.coef_two_out);
                if (result.coef_bias_out !== want.coef_bias_out)
                    $error("coef_bias_out: expected %0d, got %0d",
                           want.coef_bias_out, result.coef_bias_out);
            end
        end
        // modes: free flow, light stall, heavy stall; each held a while
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(10, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 3) == 0);
            default: result_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [15:0] pick_feature();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 8192) - 4096);
            2:       return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic sample_t pick_sample();
        sample_t s;
        int      roll;
        roll          = $urandom_range(0, 99);
        s.feature_one = pick_feature();
        s.feature_two = pick_feature();
        s.label       = 1'($urandom_range(0, 1));
        s.epoch_end   = ($urandom_range(0, 39) == 0);
        if (roll < 84)
            s.operation = OP_TRAIN;
        else if (roll < 94)
            s.operation = OP_PREDICT;
        else if (roll < 97)
            s.operation = OP_SPARE;
        else
            s.operation = OP_LOAD;
        // outside training, label and epoch_end are noise
        if (s.operation != OP_TRAIN && $urandom_range(0, 1) != 0)
            s.epoch_end = 1'b1;
        return s;
    endfunction

    task automatic queue_word(input op_t op, input logic [15:0] f1,
                              input logic [15:0] f2, input logic lab, input logic ee);
        sample_t s;
        s.operation   = op;
        s.feature_one = f1;
        s.feature_two = f2;
        s.label       = lab;
        s.epoch_end   = ee;
        pending_samples = {pending_samples, s};
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_BATCH_LENGTH:   m_batch_len  = val[10:0];
            REG_STEP_SIZE:      m_step       = val[15:0];
            REG_START_COEF_ONE: m_start_one  = val;
            REG_START_COEF_TWO: m_start_two  = val;
            default:            m_start_bias = val;
        endcase
    endtask

    task automatic write_all(input logic [31:0] bl, input logic [31:0] st,
                             input logic [31:0] c1, input logic [31:0] c2,
                             input logic [31:0] cb);
        write_reg(REG_BATCH_LENGTH, bl);
        write_reg(REG_STEP_SIZE, st);
        write_reg(REG_START_COEF_ONE, c1);
        write_reg(REG_START_COEF_TWO, c2);
        write_reg(REG_START_COEF_BIAS, cb);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || predicted_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] small_coef();
        return 32'($urandom_range(0, 262144) - 131072);
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        result_stall = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cycles       = 0;
        errors       = 0;
        burst_left   = 0;
        gap_left     = 0;
        stall_mode   = 0;
        stall_left   = 0;
        fill_luts();
        m_batch_len  = 11'd32;
        m_step       = 16'd655;
        m_start_one  = '0;
        m_start_two  = '0;
        m_start_bias = '0;
        m_coef_one   = '0;
        m_coef_two   = '0;
        m_coef_bias  = '0;
        drop_batch();
        m_loss       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at reset settings, then with large start values
        queue_word(OP_PREDICT, 16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_word(OP_TRAIN,   16'h7FFF, 16'h8000, 1'b1, 1'b0);
        queue_word(OP_TRAIN,   16'h8000, 16'h7FFF, 1'b0, 1'b0);
        queue_word(OP_TRAIN,   16'hFFFF, 16'h0001, 1'b1, 1'b0);
        queue_word(OP_SPARE,   16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
        queue_word(OP_PREDICT, 16'h8000, 16'h8000, 1'b1, 1'b1);
        queue_word(OP_TRAIN,   16'h1000, 16'hF000, 1'b0, 1'b1);
        queue_word(OP_TRAIN,   16'h0000, 16'h0000, 1'b1, 1'b1);
        queue_word(OP_LOAD,    16'h7FFF, 16'h8000, 1'b1, 1'b1);
        wait_drained();
        // z far past either end of the sigmoid table, log clamp at both ends
        write_all(32'd1, 32'd65535, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        queue_word(OP_LOAD,    16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_word(OP_PREDICT, 16'h7FFF, 16'h8000, 1'b0, 1'b0);
        queue_word(OP_PREDICT, 16'h8000, 16'h7FFF, 1'b0, 1'b0);
        queue_word(OP_TRAIN,   16'h7FFF, 16'h8000, 1'b0, 1'b0);
        queue_word(OP_TRAIN,   16'h7FFF, 16'h8000, 1'b0, 1'b0);
        queue_word(OP_TRAIN,   16'h8000, 16'h7FFF, 1'b1, 1'b0);
        queue_word(OP_TRAIN,   16'h8000, 16'h7FFF, 1'b1, 1'b1);
        queue_word(OP_LOAD,    16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_word(OP_TRAIN,   16'h8000, 16'h8000, 1'b1, 1'b0);
        queue_word(OP_TRAIN,   16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
        wait_drained();

        // random phases, each with its own register setting
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: write_all(32'd32, 32'd655, 32'd0, 32'd0, 32'd0);
                1: write_all(32'd0, 32'd0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
                2: write_all(32'd1, 32'd65535, small_coef(), small_coef(), small_coef());
                3: write_all(32'd2047, 32'd1000, small_coef(), small_coef(), 32'd0);
                4: write_all(32'd4, 32'd4000, small_coef(), small_coef(), small_coef());
                5: write_all(32'd1024, $urandom_range(0, 65535), 32'd0, 32'd0, 32'd0);
                6: write_all($urandom_range(1, 16), $urandom_range(0, 65535),
                             $urandom, $urandom, $urandom);
                default: write_all(32'd3, 32'd20000, 32'h80000000, 32'h80000000,
                                   32'h80000000);
            endcase
            queue_word(OP_LOAD, 16'h0000, 16'h0000, 1'b0, 1'b0);
            for (int n = 0; n < RND_PER_PHASE; n++)
                pending_samples = {pending_samples, pick_sample()};
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (errors == 0 && predicted_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lrst_pkg.sv
rtl/logistic_regression_sgd_trainer_unit.sv
tb/sv/tb_top.sv
